[src/touch_sample_averager_macros.svh]
// assertion helpers shared by the touch sample averager modules
`ifndef TOUCH_SAMPLE_AVERAGER_MACROS_SVH
`define TOUCH_SAMPLE_AVERAGER_MACROS_SVH

// condition that must hold at every edge out of reset
`define TSA_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// implication whose consequent is checked in the following cycle
`define TSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/tsa_pkg.sv]
package tsa_pkg;

  localparam int AVG_COUNT   = 16;
  localparam int SAMPLE_BITS = 10;

  // averaging is a right shift, so the sample count is a power of two
  localparam int AVG_SHIFT = $clog2(AVG_COUNT);
  localparam int SAMPLE_W  = 10;
  localparam int COORD_W   = 10;
  localparam int SUM_W     = SAMPLE_BITS + AVG_SHIFT;
  localparam int CNT_W     = (AVG_SHIFT < 1) ? 1 : AVG_SHIFT;

  typedef enum logic [1:0] {
    KIND_PEN  = 2'd0,
    KIND_CONV = 2'd1,
    KIND_TICK = 2'd2,
    KIND_READ = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    MODE_WAIT_DOWN = 2'd0,
    MODE_WAIT_UP   = 2'd1,
    MODE_AUTO      = 2'd2
  } mode_t;

  typedef struct packed {
    kind_t               kind;
    logic                pen_down;
    logic [SAMPLE_W-1:0] sample_x;
    logic [SAMPLE_W-1:0] sample_y;
  } event_t;

  typedef struct packed {
    logic               start_conversion;
    mode_t              panel_mode;
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;
    logic               pressed;
    logic               coord_valid;
  } result_t;

endpackage

[src/tsa_core.sv]
module tsa_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  tsa_pkg::event_t  ev,
  output tsa_pkg::result_t res
);
  import tsa_pkg::*;

  mode_t              mode_now, mode_now_next;
  logic               tick_armed, tick_armed_next;
  logic [SUM_W-1:0]   sum_x, sum_y, sum_x_next, sum_y_next;
  logic [CNT_W-1:0]   sample_count, sample_count_next;
  logic [COORD_W-1:0] held_x, held_y;
  logic               held_pressed;
  logic               held_valid, held_valid_next;

  logic               post_req;
  logic [COORD_W-1:0] post_x, post_y;
  logic               post_p;
  logic [SUM_W-1:0]   sum_x_add, sum_y_add;
  logic [SAMPLE_W-1:0] sx, sy;
  logic               last_pair;

  // samples are taken in their low SAMPLE_BITS bits
  assign sx = ev.sample_x & SAMPLE_W'((1 << SAMPLE_BITS) - 1);
  assign sy = ev.sample_y & SAMPLE_W'((1 << SAMPLE_BITS) - 1);
  assign sum_x_add = sum_x + SUM_W'(sx);
  assign sum_y_add = sum_y + SUM_W'(sy);
  assign last_pair = (sample_count == CNT_W'(AVG_COUNT - 1));

  always_comb begin
    mode_now_next     = mode_now;
    tick_armed_next   = tick_armed;
    sum_x_next        = sum_x;
    sum_y_next        = sum_y;
    sample_count_next = sample_count;
    held_valid_next   = held_valid;
    post_req          = 1'b0;
    post_x            = '0;
    post_y            = '0;
    post_p            = 1'b0;
    res               = '0;

    unique case (ev.kind)
      KIND_PEN: begin
        if (ev.pen_down) begin
          mode_now_next        = MODE_AUTO;
          res.start_conversion = 1'b1;
        end else begin
          mode_now_next = MODE_WAIT_DOWN;
          post_req      = 1'b1;
        end
      end
      KIND_CONV: begin
        if (ev.pen_down) begin
          if (last_pair) begin
            post_req          = 1'b1;
            post_x            = COORD_W'(sum_x_add >> AVG_SHIFT);
            post_y            = COORD_W'(sum_y_add >> AVG_SHIFT);
            post_p            = 1'b1;
            sum_x_next        = '0;
            sum_y_next        = '0;
            sample_count_next = '0;
            mode_now_next     = MODE_WAIT_UP;
            tick_armed_next   = 1'b1;
          end else begin
            sum_x_next           = sum_x_add;
            sum_y_next           = sum_y_add;
            sample_count_next    = sample_count + CNT_W'(1);
            mode_now_next        = MODE_AUTO;
            res.start_conversion = 1'b1;
          end
        end else begin
          tick_armed_next   = 1'b0;
          mode_now_next     = MODE_WAIT_DOWN;
          post_req          = 1'b1;
          sum_x_next        = '0;
          sum_y_next        = '0;
          sample_count_next = '0;
        end
      end
      KIND_TICK: begin
        if (tick_armed && mode_now != MODE_AUTO) begin
          if (ev.pen_down) begin
            mode_now_next        = MODE_AUTO;
            res.start_conversion = 1'b1;
          end else begin
            tick_armed_next = 1'b0;
            mode_now_next   = MODE_WAIT_DOWN;
            post_req        = 1'b1;
          end
        end
      end
      KIND_READ: begin
        if (held_valid) begin
          res.coord_x     = held_x;
          res.coord_y     = held_y;
          res.pressed     = held_pressed;
          res.coord_valid = 1'b1;
          held_valid_next = 1'b0;
        end
      end
      default: ;
    endcase

    // a post to a full mailbox is dropped
    if (post_req && !held_valid) begin
      held_valid_next = 1'b1;
    end
    res.panel_mode = mode_now_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_now     <= MODE_WAIT_DOWN;
      tick_armed   <= 1'b0;
      sum_x        <= '0;
      sum_y        <= '0;
      sample_count <= '0;
      held_x       <= '0;
      held_y       <= '0;
      held_pressed <= 1'b0;
      held_valid   <= 1'b0;
    end else if (adv) begin
      mode_now     <= mode_now_next;
      tick_armed   <= tick_armed_next;
      sum_x        <= sum_x_next;
      sum_y        <= sum_y_next;
      sample_count <= sample_count_next;
      held_valid   <= held_valid_next;
      if (post_req && !held_valid) begin
        held_x       <= post_x;
        held_y       <= post_y;
        held_pressed <= post_p;
      end
    end
  end

`include "touch_sample_averager_macros.svh"

  `TSA_ASSERT_NEXT(a_read_empties, adv && ev.kind == KIND_READ, !held_valid, "read left mailbox full")
  `TSA_ASSERT_NEXT(a_mailbox_holds, held_valid && !(adv && ev.kind == KIND_READ), held_valid, "mailbox lost its entry")
  `TSA_ASSERT_ALWAYS(a_start_auto, !res.start_conversion || res.panel_mode == MODE_AUTO, "conversion without auto mode")

endmodule

[src/touch_sample_averager.sv]
// touch sample averager: pen, conversion, tick and read events in, one result per event out.
// input channel: in_valid / in_stall with kind, pen_down, sample_x, sample_y; a transaction
// completes at a rising edge with in_valid high and in_stall low.
// output channel: out_valid / out_stall with start_conversion, panel_mode, coord_x, coord_y,
// pressed and coord_valid; one result transaction per input transaction, in order.
// an event is registered at acceptance, handled by the core once the result register is free
// or being taken, and its result registered, from where it shows on the output until taken.
// throughput: one event per cycle without stalls; the sequencer state updates in one pass
// of add, compare and shift logic between the event register and the result register.
// when the receiver stalls, the result register holds and the event register still takes
// one more event; in_stall rises only when both are full and the result is not taken.
// reset (rst, synchronous, active high) empties both registers, returns the panel to wait
// for pen down, disarms the repeat tick, clears the sums and empties the mailbox.
module touch_sample_averager (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    kind,
  input  logic                          pen_down,
  input  logic [tsa_pkg::SAMPLE_W-1:0]  sample_x,
  input  logic [tsa_pkg::SAMPLE_W-1:0]  sample_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          start_conversion,
  output logic [1:0]                    panel_mode,
  output logic [tsa_pkg::COORD_W-1:0]   coord_x,
  output logic [tsa_pkg::COORD_W-1:0]   coord_y,
  output logic                          pressed,
  output logic                          coord_valid
);
  import tsa_pkg::*;

  logic    ev_valid;
  event_t  ev;
  logic    adv;
  logic    in_take;
  result_t res_comb;
  result_t res;

  assign adv      = ev_valid && (!out_valid || !out_stall);
  assign in_stall = ev_valid && !adv;
  assign in_take  = in_valid && !in_stall;

  tsa_core u_core (
    .clk (clk),
    .rst (rst),
    .adv (adv),
    .ev  (ev),
    .res (res_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_take) begin
        ev_valid <= 1'b1;
      end else if (adv) begin
        ev_valid <= 1'b0;
      end
      if (adv) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      ev.kind     <= kind_t'(kind);
      ev.pen_down <= pen_down;
      ev.sample_x <= sample_x;
      ev.sample_y <= sample_y;
    end
    if (adv) begin
      res <= res_comb;
    end
  end

  assign start_conversion = res.start_conversion;
  assign panel_mode       = res.panel_mode;
  assign coord_x          = res.coord_x;
  assign coord_y          = res.coord_y;
  assign pressed          = res.pressed;
  assign coord_valid      = res.coord_valid;

`include "touch_sample_averager_macros.svh"

  `TSA_ASSERT_NEXT(a_event_kept, ev_valid && !adv, ev_valid, "pending event dropped")
  `TSA_ASSERT_ALWAYS(a_stall_only_full, !in_stall || (ev_valid && out_valid), "stall with free slot")
  `TSA_ASSERT_NEXT(a_result_shown, adv, out_valid, "handled event gave no result")

endmodule

[test/touch_sample_averager_test.sv]
module touch_sample_averager_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tsa_pkg::*;

  localparam int EVENT_TARGET = 600;
  localparam int QUIET_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 90;

  // tracks the panel sequencer and keeps the results it still owes
  class panel_tracker;
    mode_t        mode = MODE_WAIT_DOWN;
    bit           tick_on = 1'b0;
    int unsigned  acc_x = 0;
    int unsigned  acc_y = 0;
    int unsigned  pairs = 0;
    logic [9:0]   box_x = '0;
    logic [9:0]   box_y = '0;
    logic         box_pressed = 1'b0;
    logic         box_full = 1'b0;
    result_t      due_reports[$];

    function void post_coords(logic [9:0] x, logic [9:0] y, logic p);
      if (!box_full) begin
        box_x = x;
        box_y = y;
        box_pressed = p;
        box_full = 1'b1;
      end
    endfunction

    function void clear_acc();
      acc_x = 0;
      acc_y = 0;
      pairs = 0;
    endfunction

    function void take_event(kind_t k, logic down, logic [9:0] sx, logic [9:0] sy);
      result_t r;
      r = '0;
      case (k)
        KIND_PEN: begin
          if (down) begin
            mode = MODE_AUTO;
            r.start_conversion = 1'b1;
          end else begin
            mode = MODE_WAIT_DOWN;
            post_coords('0, '0, 1'b0);
          end
        end
        KIND_CONV: begin
          if (down) begin
            acc_x += sx;
            acc_y += sy;
            pairs++;
            if (pairs >= AVG_COUNT) begin
              post_coords(10'(acc_x / AVG_COUNT), 10'(acc_y / AVG_COUNT), 1'b1);
              clear_acc();
              mode = MODE_WAIT_UP;
              tick_on = 1'b1;
            end else begin
              mode = MODE_AUTO;
              r.start_conversion = 1'b1;
            end
          end else begin
            tick_on = 1'b0;
            mode = MODE_WAIT_DOWN;
            post_coords('0, '0, 1'b0);
            clear_acc();
          end
        end
        KIND_TICK: begin
          // ignored unless armed and not already measuring
          if (tick_on && mode != MODE_AUTO) begin
            if (down) begin
              mode = MODE_AUTO;
              r.start_conversion = 1'b1;
            end else begin
              tick_on = 1'b0;
              mode = MODE_WAIT_DOWN;
              post_coords('0, '0, 1'b0);
            end
          end
        end
        default: begin
          if (box_full) begin
            r.coord_x = box_x;
            r.coord_y = box_y;
            r.pressed = box_pressed;
            r.coord_valid = 1'b1;
            box_full = 1'b0;
          end
        end
      endcase
      r.panel_mode = mode;
      due_reports.push_back(r);
    endfunction

    function string match_report(result_t got);
      result_t want;
      string   why;
      why = "";
      if (due_reports.size() == 0) return "result with nothing pending";
      want = due_reports.pop_front();
      if (got.start_conversion !== want.start_conversion)
        why = {why, $sformatf(" start_conversion %0b/%0b", got.start_conversion,
                              want.start_conversion)};
      if (got.panel_mode !== want.panel_mode)
        why = {why, $sformatf(" panel_mode %0d/%0d", got.panel_mode, want.panel_mode)};
      if (got.coord_x !== want.coord_x)
        why = {why, $sformatf(" coord_x %0d/%0d", got.coord_x, want.coord_x)};
      if (got.coord_y !== want.coord_y)
        why = {why, $sformatf(" coord_y %0d/%0d", got.coord_y, want.coord_y)};
      if (got.pressed !== want.pressed)
        why = {why, $sformatf(" pressed %0b/%0b", got.pressed, want.pressed)};
      if (got.coord_valid !== want.coord_valid)
        why = {why, $sformatf(" coord_valid %0b/%0b", got.coord_valid, want.coord_valid)};
      return why;
    endfunction

    function int pending();
      return due_reports.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [1:0]          kind;
  logic                pen_down;
  logic [SAMPLE_W-1:0] sample_x;
  logic [SAMPLE_W-1:0] sample_y;
  logic                out_valid;
  logic                out_stall;
  logic                start_conversion;
  logic [1:0]          panel_mode;
  logic [COORD_W-1:0]  coord_x;
  logic [COORD_W-1:0]  coord_y;
  logic                pressed;
  logic                coord_valid;

  panel_tracker tracker = new();
  int  errors = 0;
  int  sent = 0;
  int  burst_left = 0;
  int  quiet = 0;
  bit  want_hold = 1'b0;

  touch_sample_averager uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .kind(kind),
    .pen_down(pen_down),
    .sample_x(sample_x),
    .sample_y(sample_y),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .start_conversion(start_conversion),
    .panel_mode(panel_mode),
    .coord_x(coord_x),
    .coord_y(coord_y),
    .pressed(pressed),
    .coord_valid(coord_valid)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report(string msg);
    $display("mismatch at %0t:%s", $realtime, msg);
    errors++;
  endtask

  task automatic idle(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // bursts of random length, mostly separated by short gaps
  task automatic pace();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) idle($urandom_range(1, 6));
    end
    burst_left--;
  endtask

  task automatic send_event(kind_t k, logic p, logic [9:0] x, logic [9:0] y);
    pace();
    in_valid <= 1'b1;
    kind <= k;
    pen_down <= p;
    sample_x <= x;
    sample_y <= y;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.take_event(k, p, x, y);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [9:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 10'd0;
      1: return 10'd1023;
      default: return 10'($urandom_range(0, 1023));
    endcase
  endfunction

  task automatic send_noise();
    send_event(kind_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
               pick_sample(), pick_sample());
  endtask

  // optional pen down, one or more averaging rounds with repeat ticks, optional release, then a read
  task automatic run_gesture();
    int rounds;
    int count;
    if ($urandom_range(0, 4) != 0) send_event(KIND_PEN, 1'b1, pick_sample(), pick_sample());
    rounds = $urandom_range(1, 3);
    for (int r = 0; r < rounds; r++) begin
      count = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 20) : AVG_COUNT;
      for (int i = 0; i < count; i++) begin
        if ($urandom_range(0, 11) == 0) send_noise();
        send_event(KIND_CONV, 1'b1, pick_sample(), pick_sample());
      end
      if ($urandom_range(0, 1) != 0)
        send_event(KIND_READ, 1'($urandom_range(0, 1)), pick_sample(), pick_sample());
      send_event(KIND_TICK, 1'b1, pick_sample(), pick_sample());
    end
    case ($urandom_range(0, 3))
      0: send_event(KIND_PEN, 1'b0, pick_sample(), pick_sample());
      1: send_event(KIND_TICK, 1'b0, pick_sample(), pick_sample());
      2: send_event(KIND_CONV, 1'b0, pick_sample(), pick_sample());
      default: ;
    endcase
    send_event(KIND_READ, 1'($urandom_range(0, 1)), pick_sample(), pick_sample());
  endtask

  // receiver: changing stall styles, plus one long hold on request
  initial begin
    int style;
    int left;
    int hold;
    style = 0;
    left = 0;
    hold = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (want_hold) begin
        want_hold = 1'b0;
        hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else begin
        if (left == 0) begin
          style = $urandom_range(0, 3);
          left = $urandom_range(20, 80);
        end
        left--;
        case (style)
          0: out_stall <= 1'b0;
          1: out_stall <= 1'($urandom_range(0, 1));
          2: out_stall <= (left % 3 == 0);
          default: out_stall <= ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    result_t got;
    string   why;
    if (!rst && out_valid && !out_stall) begin
      got.start_conversion = start_conversion;
      got.panel_mode = mode_t'(panel_mode);
      got.coord_x = coord_x;
      got.coord_y = coord_y;
      got.pressed = pressed;
      got.coord_valid = coord_valid;
      why = tracker.match_report(got);
      if (why != "") report(why);
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    bit hold_done;
    bit drain_done;
    hold_done = 1'b0;
    drain_done = 1'b0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    kind <= KIND_PEN;
    pen_down <= 1'b0;
    sample_x <= '0;
    sample_y <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // read of an empty mailbox, tick before arming
    send_event(KIND_READ, 1'b0, 10'd0, 10'd0);
    send_event(KIND_PEN, 1'b1, 10'd0, 10'd0);
    send_event(KIND_TICK, 1'b1, 10'd1023, 10'd1023);
    // full averaging round at the sample extremes
    repeat (AVG_COUNT) send_event(KIND_CONV, 1'b1, 10'd1023, 10'd0);
    // pen up into a full mailbox is dropped
    send_event(KIND_PEN, 1'b0, 10'd0, 10'd0);
    send_event(KIND_READ, 1'b1, 10'd0, 10'd0);
    // armed tick with pen up posts zeros
    send_event(KIND_TICK, 1'b0, 10'd0, 10'd0);
    send_event(KIND_READ, 1'b0, 10'd0, 10'd0);
    send_event(KIND_CONV, 1'b0, 10'd1023, 10'd1023);
    send_event(KIND_READ, 1'b0, 10'd0, 10'd0);

    while (sent < EVENT_TARGET) begin
      if (!hold_done && sent >= 150) begin
        hold_done = 1'b1;
        want_hold = 1'b1;
      end
      if (!drain_done && sent >= 350) begin
        drain_done = 1'b1;
        drain();
      end
      case ($urandom_range(0, 9))
        7: repeat ($urandom_range(1, 8)) send_noise();
        8: send_event(KIND_READ, 1'($urandom_range(0, 1)), pick_sample(), pick_sample());
        9: begin
          send_event(KIND_PEN, 1'b1, pick_sample(), pick_sample());
          repeat ($urandom_range(1, 6))
            send_event(KIND_CONV, 1'b1, pick_sample(), pick_sample());
          send_event(KIND_CONV, 1'b0, pick_sample(), pick_sample());
        end
        default: run_gesture();
      endcase
    end

    drain();
    repeat (10) @(posedge clk);
    if (tracker.pending() != 0) report(" results never arrived");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
